/* sv/brti_pkg.sv */
// ----------------------------------------------------------------------------
// brti_pkg
// Shared types for the branch ring triangle indexer: controller states,
// triangle kinds and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package brti_pkg;

    localparam int IN_DATA_W = 40;
    localparam int IN_USER_W = 2;
    localparam int FIRST_W   = 16;
    localparam int SIZE_IN_W = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAP,
        ST_RING_A,
        ST_RING_B,
        ST_MAP_A,
        ST_MAP_B
    } t_state;

    typedef enum logic [2:0] {
        TRI_CAP,
        TRI_RING_A,
        TRI_RING_B,
        TRI_MAP_A,
        TRI_MAP_B
    } t_tri;

    typedef struct packed {
        logic load;
        logic emit;
        logic last;
        logic cnt_clr;
        logic cnt_inc;
        t_tri kind;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic in_leaf;
        logic in_map;
        logic map;
        logic cap_last;
        logic cnt_last;
        logic split;
    } t_status;

endpackage

/* sv/brti_ctrl.sv */
// ----------------------------------------------------------------------------
// brti_ctrl
// Sequencer: walks cap fan, ring stitch or mapped stitch, one triangle per
// cycle whenever the output register can take it.
// ----------------------------------------------------------------------------
module brti_ctrl
    import brti_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  t_status i_status,
    output logic    o_s_tready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_s_tready    = 1'b0;
        o_cmd         = '0;
        o_cmd.kind    = TRI_CAP;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.in_leaf) begin
                        n_state = ST_CAP;
                    end else if (i_status.in_map) begin
                        n_state = ST_MAP_A;
                    end else begin
                        n_state = ST_RING_A;
                    end
                end
            end
            ST_CAP: begin
                if (i_status.go) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = TRI_CAP;
                    if (i_status.cap_last) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state = i_status.map ? ST_MAP_A : ST_RING_A;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_RING_A: begin
                if (i_status.go) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = TRI_RING_A;
                    n_state    = ST_RING_B;
                end
            end
            ST_RING_B: begin
                if (i_status.go) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = TRI_RING_B;
                    if (i_status.cnt_last) begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = ST_RING_A;
                    end
                end
            end
            ST_MAP_A: begin
                if (i_status.go) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = TRI_MAP_A;
                    if (i_status.split) begin
                        n_state = ST_MAP_B;
                    end else if (i_status.cnt_last) begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_MAP_B: begin
                if (i_status.go) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = TRI_MAP_B;
                    if (i_status.cnt_last) begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = ST_MAP_A;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit && o_cmd.last |=> r_state == ST_IDLE)
        else $error("last triangle did not return sequencer to idle");

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.go)
        else $error("triangle issued while output slot busy");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state != ST_IDLE)
        else $error("load left sequencer idle");

endmodule

/* sv/brti_dp.sv */
// ----------------------------------------------------------------------------
// brti_dp
// Datapath: node registers, vertex counter, incremental round-half-up ring
// mapping (one compare/subtract per step) and the registered output slot.
// ----------------------------------------------------------------------------
module brti_dp
    import brti_pkg::*;
#(
    parameter int MAX_RING   = 8,
    parameter int INDEX_BITS = 16,
    parameter int OUT_DATA_W = 48
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    input  logic                  i_m_tready,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    localparam int IW = INDEX_BITS;
    localparam int RW = $clog2(MAX_RING + 1);
    localparam int CW = $clog2(MAX_RING);
    localparam int DW = $clog2(2 * MAX_RING);

    function automatic logic [RW-1:0] clamp_size(input logic [SIZE_IN_W-1:0] s);
        logic [SIZE_IN_W:0] e;
        e = {1'b0, s};
        if (e < (SIZE_IN_W+1)'(3)) begin
            return RW'(3);
        end else if (e > (SIZE_IN_W+1)'(MAX_RING)) begin
            return RW'(MAX_RING);
        end
        return RW'(e);
    endfunction

    logic [RW-1:0] in_n, in_p, in_s, in_b;
    logic [IW-1:0] in_l, in_pf;
    logic          in_main, in_leaf, in_map, in_node_small;

    assign in_l          = IW'(i_s_tdata[15:0]);
    assign in_n          = clamp_size(i_s_tdata[19:16]);
    assign in_pf         = IW'(i_s_tdata[35:20]);
    assign in_p          = clamp_size(i_s_tdata[39:36]);
    assign in_main       = i_s_tuser[0];
    assign in_leaf       = i_s_tuser[1];
    assign in_map        = in_main && (in_n != in_p);
    assign in_node_small = in_n < in_p;
    assign in_s          = in_node_small ? in_n : in_p;
    assign in_b          = in_node_small ? in_p : in_n;

    logic [IW-1:0] r_l, r_far, r_big_first, r_small_first;
    logic [RW-1:0] r_n, r_span, r_b;
    logic          r_map;
    logic [DW-1:0] r_den, r_step, r_rem;
    logic [CW-1:0] r_cnt, r_m;

    logic          r_out_valid, r_out_last;
    logic [IW-1:0] r_ca, r_cb, r_cc;

    logic          go, cnt_last, cap_last, m_inc, split;
    logic [RW:0]   cnt_ext;
    logic [CW-1:0] v2, m_next, m2;
    logic [DW:0]   rem_sum;
    logic [DW-1:0] rem_next;
    logic [IW-1:0] a, b, c, v1i, v2i;

    assign go       = !r_out_valid || i_m_tready;
    assign cnt_ext  = (RW+1)'(r_cnt);
    assign cnt_last = (cnt_ext + (RW+1)'(1)) == {1'b0, r_span};
    assign cap_last = (cnt_ext + (RW+1)'(3)) == {1'b0, r_n};
    assign v2       = cnt_last ? '0 : r_cnt + CW'(1);

    assign rem_sum  = {1'b0, r_rem} + {1'b0, r_step};
    assign m_inc    = rem_sum >= {1'b0, r_den};
    assign rem_next = m_inc ? DW'(rem_sum - {1'b0, r_den}) : DW'(rem_sum);
    assign m_next   = r_m + CW'(m_inc);
    assign m2       = cnt_last ? '0 : m_next;
    assign split    = m2 != r_m;

    assign v1i = IW'(r_cnt);
    assign v2i = IW'(v2);

    always_comb begin
        a = r_l;
        b = r_l;
        c = r_l;
        case (i_cmd.kind)
            TRI_CAP: begin
                a = r_l;
                b = r_l + v1i + IW'(2);
                c = r_l + v1i + IW'(1);
            end
            TRI_RING_A: begin
                a = r_l + v1i;
                b = r_l + v2i;
                c = r_far + v1i;
            end
            TRI_RING_B: begin
                a = r_l + v2i;
                b = r_far + v2i;
                c = r_far + v1i;
            end
            TRI_MAP_A: begin
                a = r_big_first + v2i;
                b = r_big_first + v1i;
                c = r_small_first + IW'(r_m);
            end
            TRI_MAP_B: begin
                a = r_big_first + v2i;
                b = r_small_first + IW'(r_m);
                c = r_small_first + IW'(m2);
            end
            default: begin
                a = r_l;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_m         <= '0;
            r_rem       <= '0;
            r_den       <= DW'(4);
            r_span      <= RW'(3);
            r_map       <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_map  <= in_map;
                r_span <= in_map ? in_b : in_n;
                r_den  <= DW'(2 * (int'(in_b) - 1));
            end
            if (i_cmd.load || i_cmd.cnt_clr) begin
                r_cnt <= '0;
                r_m   <= '0;
                r_rem <= i_cmd.load ? DW'(in_b - RW'(1)) : DW'(r_b - RW'(1));
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
                r_m   <= m_next;
                r_rem <= rem_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_l           <= in_l;
            r_n           <= in_n;
            r_b           <= in_b;
            r_far         <= in_main ? in_pf : in_l + IW'(in_n);
            r_big_first   <= in_node_small ? in_pf : in_l;
            r_small_first <= in_node_small ? in_l : in_pf;
            r_step        <= DW'(2 * (int'(in_s) - 1));
        end
        if (i_cmd.emit) begin
            r_ca       <= a;
            r_cb       <= b;
            r_cc       <= c;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_status.go       = go;
    assign o_status.in_leaf  = in_leaf;
    assign o_status.in_map   = in_map;
    assign o_status.map      = r_map;
    assign o_status.cap_last = cap_last;
    assign o_status.cnt_last = cnt_last;
    assign o_status.split    = split;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_cc, r_cb, r_ca});
    assign o_m_tlast  = r_out_last;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_map |-> r_rem < r_den)
        else $error("mapping remainder out of range");

    a_cnt_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (RW+1)'(r_cnt) < {1'b0, r_span})
        else $error("vertex counter beyond ring");

    a_map_in_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_map |-> (DW+1)'(r_m) * 2 <= (DW+1)'(r_step))
        else $error("mapped vertex beyond smaller ring");

endmodule

/* sv/branch_ring_triangle_indexer.sv */
// ----------------------------------------------------------------------------
// branch_ring_triangle_indexer
// Turns one branch node into index triangles: leaf cap fan, then a ring
// stitch to its own base ring, to an equal parent ring, or a mapped stitch
// between rings of different size.
//
//   port group  dir  payload (lsb first)
//   s_*         in   first[15:0] size[19:16] parent_first[35:20]
//                    parent_size[39:36]; tuser main[0] leaf[1]
//   m_*         out  corner_a, corner_b, corner_c (INDEX_BITS each); tlast
//
// An item is loaded, then the single triangle sequencer issues its
// triangles one per cycle while the output register can take them.
// The next item is taken once the last triangle sits in the output register.
// A stalled output holds the sequencer; nothing is dropped.
// Reset is synchronous, active low, and clears sequencer and output valid.
// ----------------------------------------------------------------------------
module branch_ring_triangle_indexer
    import brti_pkg::*;
#(
    parameter int MAX_RING   = 8,
    parameter int INDEX_BITS = 16
)(
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // node_first_vertex, node_ring_size, parent_first_vertex, parent_ring_size
    input  logic [IN_DATA_W-1:0]                    i_s_tdata,
    // is_main_continuation, is_leaf
    input  logic [IN_USER_W-1:0]                    i_s_tuser,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // corner_a, corner_b, corner_c, zero padded to bytes
    output logic [((3*INDEX_BITS+7)/8)*8-1:0]       o_m_tdata,
    // last_triangle
    output logic                                    o_m_tlast
);

    localparam int OUT_DATA_W = ((3 * INDEX_BITS + 7) / 8) * 8;

    t_cmd    cmd;
    t_status status;

    brti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    brti_dp #(
        .MAX_RING   (MAX_RING),
        .INDEX_BITS (INDEX_BITS),
        .OUT_DATA_W (OUT_DATA_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

/* verif/brti_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brti_checker
// Watches both stream channels of the branch ring triangle indexer. Each
// node transaction is expanded into its expected triangles: leaf cap fan,
// then the side branch, equal ring or mapped ring stitch. Every triangle
// transaction is compared with the oldest expected triangle.
// ----------------------------------------------------------------------------
module brti_checker
    import brti_pkg::*;
#(
    parameter int MAX_RING   = 8,
    parameter int INDEX_BITS = 16
)(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // node_first_vertex, node_ring_size, parent_first_vertex, parent_ring_size
    input  logic [IN_DATA_W-1:0]              i_s_tdata,
    // is_main_continuation, is_leaf
    input  logic [IN_USER_W-1:0]              i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // corner_a, corner_b, corner_c, zero padded to bytes
    input  logic [((3*INDEX_BITS+7)/8)*8-1:0] i_m_tdata,
    // last_triangle
    input  logic                              i_m_tlast,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_tri_count
);

    typedef logic [INDEX_BITS-1:0] t_index;

    typedef struct packed {
        t_index a;
        t_index b;
        t_index c;
        logic   last;
    } t_triangle;

    t_triangle expected_tris[$];
    t_triangle got_tri;
    t_triangle want_tri;
    int        fail_total = 0;
    int        tri_total  = 0;

    assign o_fail_count = fail_total;
    assign o_tri_count  = tri_total;

    task automatic report_mismatch(input string what);
        fail_total++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int sat_ring(input int s);
        if (s < 3) begin
            return 3;
        end
        if (s > MAX_RING) begin
            return MAX_RING;
        end
        return s;
    endfunction

    // round-half-up of v*(s-1)/(b-1)
    function automatic int ring_map(input int v, input int s, input int b);
        return (2 * v * (s - 1) + (b - 1)) / (2 * (b - 1));
    endfunction

    function automatic t_triangle make_tri(input int a, input int b, input int c);
        t_triangle t;
        t.a    = t_index'(a);
        t.b    = t_index'(b);
        t.c    = t_index'(c);
        t.last = 1'b0;
        return t;
    endfunction

    function automatic void predict_triangles(input logic [IN_DATA_W-1:0] data,
                                              input logic [IN_USER_W-1:0] user);
        t_triangle batch [0:63];
        int        own_first;
        int        own_n;
        int        par_first;
        int        par_n;
        int        sm_first;
        int        sm_n;
        int        bg_first;
        int        bg_n;
        int        v2;
        int        m1;
        int        m2;
        int        k;
        logic      cont;
        logic      leaf;
        own_first = int'(data[FIRST_W-1:0]);
        own_n     = sat_ring(int'(data[FIRST_W +: SIZE_IN_W]));
        par_first = int'(data[FIRST_W+SIZE_IN_W +: FIRST_W]);
        par_n     = sat_ring(int'(data[2*FIRST_W+SIZE_IN_W +: SIZE_IN_W]));
        cont      = user[0];
        leaf      = user[1];
        k         = 0;
        if (leaf) begin
            for (int j = 1; j + 1 < own_n; j++) begin
                batch[k] = make_tri(own_first, own_first + j + 1, own_first + j);
                k++;
            end
        end
        if (!cont) begin
            for (int v1 = 0; v1 < own_n; v1++) begin
                v2 = (v1 + 1) % own_n;
                batch[k] = make_tri(own_first + v1, own_first + v2, own_first + own_n + v1);
                k++;
                batch[k] = make_tri(own_first + v2, own_first + own_n + v2,
                                    own_first + own_n + v1);
                k++;
            end
        end else if (own_n == par_n) begin
            for (int v1 = 0; v1 < own_n; v1++) begin
                v2 = (v1 + 1) % own_n;
                batch[k] = make_tri(own_first + v1, own_first + v2, par_first + v1);
                k++;
                batch[k] = make_tri(own_first + v2, par_first + v2, par_first + v1);
                k++;
            end
        end else begin
            if (own_n < par_n) begin
                sm_n     = own_n;
                sm_first = own_first;
                bg_n     = par_n;
                bg_first = par_first;
            end else begin
                sm_n     = par_n;
                sm_first = par_first;
                bg_n     = own_n;
                bg_first = own_first;
            end
            for (int v1 = 0; v1 < bg_n; v1++) begin
                v2 = (v1 + 1) % bg_n;
                m1 = ring_map(v1, sm_n, bg_n);
                m2 = ring_map(v2, sm_n, bg_n);
                batch[k] = make_tri(bg_first + v2, bg_first + v1, sm_first + m1);
                k++;
                if (m1 != m2) begin
                    batch[k] = make_tri(bg_first + v2, sm_first + m1, sm_first + m2);
                    k++;
                end
            end
        end
        batch[k-1].last = 1'b1;
        for (int i = 0; i < k; i++) begin
            expected_tris = {expected_tris, batch[i]};
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_tris.delete();
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                predict_triangles(i_s_tdata, i_s_tuser);
            end
            if (i_m_tvalid && i_m_tready) begin
                tri_total++;
                got_tri.a    = i_m_tdata[0 +: INDEX_BITS];
                got_tri.b    = i_m_tdata[INDEX_BITS +: INDEX_BITS];
                got_tri.c    = i_m_tdata[2*INDEX_BITS +: INDEX_BITS];
                got_tri.last = i_m_tlast;
                if (expected_tris.size() == 0) begin
                    report_mismatch($sformatf("triangle %0d (%h %h %h) with nothing expected",
                                              tri_total, got_tri.a, got_tri.b, got_tri.c));
                end else begin
                    want_tri = expected_tris.pop_front();
                    if (got_tri.a !== want_tri.a) begin
                        report_mismatch($sformatf("triangle %0d corner_a %h, expected %h",
                                                  tri_total, got_tri.a, want_tri.a));
                    end
                    if (got_tri.b !== want_tri.b) begin
                        report_mismatch($sformatf("triangle %0d corner_b %h, expected %h",
                                                  tri_total, got_tri.b, want_tri.b));
                    end
                    if (got_tri.c !== want_tri.c) begin
                        report_mismatch($sformatf("triangle %0d corner_c %h, expected %h",
                                                  tri_total, got_tri.c, want_tri.c));
                    end
                    if (got_tri.last !== want_tri.last) begin
                        report_mismatch($sformatf("triangle %0d last_triangle %b, expected %b",
                                                  tri_total, got_tri.last, want_tri.last));
                    end
                end
            end
            o_pending <= expected_tris.size();
        end
    end

endmodule

/* verif/branch_ring_triangle_indexer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// branch_ring_triangle_indexer_tb
// Drives branch node transactions into the indexer: a directed set of ring
// size corners, wrap-around indices and saturated sizes, then random nodes
// in bursts. The output side stalls on its own pattern; the checker beside
// the block predicts and compares every triangle.
// ----------------------------------------------------------------------------
module branch_ring_triangle_indexer_tb
    import brti_pkg::*;
();

    localparam int MAX_RING   = 8;
    localparam int INDEX_BITS = 16;
    localparam int OUT_W      = ((3*INDEX_BITS+7)/8)*8;
    localparam int RAND_NODES = 350;

    typedef struct packed {
        logic [FIRST_W-1:0]   first;
        logic [SIZE_IN_W-1:0] size;
        logic [FIRST_W-1:0]   pfirst;
        logic [SIZE_IN_W-1:0] psize;
        logic                 main;
        logic                 leaf;
    } t_node;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0] s_tdata  = '0;
    logic [IN_USER_W-1:0] s_tuser  = '0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [OUT_W-1:0]     m_tdata;
    wire                  m_tlast;

    int fail_count;
    int pending;
    int tri_count;

    int nodes_sent  = 0;
    int leaf_nodes  = 0;
    int side_nodes  = 0;
    int sat_nodes   = 0;
    int burst_left  = 0;
    int ready_run   = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    branch_ring_triangle_indexer #(
        .MAX_RING   (MAX_RING),
        .INDEX_BITS (INDEX_BITS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    brti_checker #(
        .MAX_RING   (MAX_RING),
        .INDEX_BITS (INDEX_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_tri_count  (tri_count)
    );

    // output stalls: open stretches, short stalls, random toggling
    always @(posedge clk) begin
        if (ready_run > 0) begin
            ready_run--;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    m_tready  <= 1'b1;
                    ready_run = $urandom_range(20, 80);
                end
                1: begin
                    m_tready  <= 1'b0;
                    ready_run = $urandom_range(0, 5);
                end
                default: begin
                    m_tready  <= 1'($urandom);
                    ready_run = $urandom_range(0, 8) == 0 ? 3 : 0;
                end
            endcase
        end
    end

    function automatic t_node mk_node(input int first, input int size, input int pfirst,
                                      input int psize, input bit main, input bit leaf);
        t_node nd;
        nd.first  = FIRST_W'(first);
        nd.size   = SIZE_IN_W'(size);
        nd.pfirst = FIRST_W'(pfirst);
        nd.psize  = SIZE_IN_W'(psize);
        nd.main   = main;
        nd.leaf   = leaf;
        return nd;
    endfunction

    function automatic t_node random_node();
        t_node nd;
        nd.first  = FIRST_W'($urandom);
        nd.pfirst = FIRST_W'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            nd.first = FIRST_W'(16'hFFFF - $urandom_range(0, 20));
        end
        if ($urandom_range(0, 19) == 0) begin
            nd.size = SIZE_IN_W'($urandom);
        end else begin
            nd.size = SIZE_IN_W'($urandom_range(3, MAX_RING));
        end
        if ($urandom_range(0, 2) == 0) begin
            nd.psize = nd.size;
        end else if ($urandom_range(0, 19) == 0) begin
            nd.psize = SIZE_IN_W'($urandom);
        end else begin
            nd.psize = SIZE_IN_W'($urandom_range(3, MAX_RING));
        end
        nd.main = $urandom_range(0, 3) != 0;
        nd.leaf = 1'($urandom);
        return nd;
    endfunction

    task automatic send_node(input t_node nd);
        s_tdata  <= {nd.psize, nd.pfirst, nd.size, nd.first};
        s_tuser  <= {nd.leaf, nd.main};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        nodes_sent++;
        if (nd.leaf) begin
            leaf_nodes++;
        end
        if (!nd.main) begin
            side_nodes++;
        end
        if (nd.size < 3 || nd.size > MAX_RING || nd.psize < 3 || nd.psize > MAX_RING) begin
            sat_nodes++;
        end
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_triangles();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_paced(input t_node nd);
        send_node(nd);
        pace_sender();
    endtask

    initial begin
        #5_000_000;
        $display("timeout: block stopped making progress");
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_paced(mk_node(16'h1000, 8, 16'h0000, 3, 0, 1));
        send_paced(mk_node(16'h0000, 3, 16'hFFFF, 8, 0, 1));
        send_paced(mk_node(16'hFFFA, 5, 16'h1234, 5, 0, 0));
        send_paced(mk_node(16'h0100, 3, 16'h0080, 3, 1, 1));
        send_paced(mk_node(16'hFFFC, 8, 16'hFFF0, 8, 1, 0));
        send_paced(mk_node(16'h4321, 6, 16'h4300, 6, 1, 1));
        send_paced(mk_node(16'h2000, 3, 16'h1F00, 8, 1, 0));
        send_paced(mk_node(16'h3000, 8, 16'h2FF0, 3, 1, 1));
        send_paced(mk_node(16'h5000, 4, 16'h4FF0, 7, 1, 0));
        send_paced(mk_node(16'h6000, 7, 16'h5FF0, 4, 1, 1));
        send_paced(mk_node(16'h7000, 5, 16'h6FF0, 6, 1, 0));
        send_paced(mk_node(16'h8000, 6, 16'h7FF0, 5, 1, 1));
        send_paced(mk_node(16'hFFFF, 8, 16'hFFFE, 3, 1, 1));
        send_paced(mk_node(16'h0000, 3, 16'h0000, 4, 1, 0));
        send_paced(mk_node(16'hFFFF, 8, 16'hFFFF, 8, 1, 1));
        send_paced(mk_node(16'h0500, 0, 16'h0600, 15, 1, 0));
        send_paced(mk_node(16'h0700, 15, 16'h0800, 2, 1, 1));
        send_paced(mk_node(16'hFFF8, 15, 16'h0000, 0, 0, 1));
        send_paced(mk_node(16'h0900, 9, 16'h0A00, 9, 1, 0));
        send_paced(mk_node(16'h0B00, 1, 16'h0C00, 3, 1, 1));
        send_node(mk_node(16'hAAAA, 2, 16'h5555, 6, 0, 0));
        drain_triangles();

        for (int i = 0; i < RAND_NODES; i++) begin
            send_node(random_node());
            if (i == RAND_NODES - 1) begin
                drain_triangles();
            end else if ($urandom_range(0, 59) == 0) begin
                drain_triangles();
            end else begin
                pace_sender();
            end
        end
        repeat (30) @(posedge clk);

        $display("Sent %0d branch nodes: %0d leaf, %0d side branch, %0d with saturated sizes",
                 nodes_sent, leaf_nodes, side_nodes, sat_nodes);
        $display("Checked %0d triangles, %0d mismatches", tri_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/brti_pkg.sv
sv/brti_ctrl.sv
sv/brti_dp.sv
sv/branch_ring_triangle_indexer.sv
verif/brti_checker.sv
verif/branch_ring_triangle_indexer_tb.sv
